// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/lcm_pkg.sv =====
`timescale 1ns / 1ps

package lcm_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int RESULT_WIDTH  = 2 * OPERAND_WIDTH - 2;
   localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH);
   localparam int PC_WIDTH      = 3;

   // datapath operations, one per microcode step
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_CLEAR,
      OP_GCD_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL,
      OP_EMIT,
      OP_NOP
   } lcm_op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ANY_ZERO,
      COND_NOT_EQUAL,
      COND_DIV_MORE,
      COND_OUT_FREE
   } lcm_cond_type;

   typedef struct packed {
      lcm_op_type            op;
      lcm_cond_type          cond;
      logic [PC_WIDTH-1:0]   target;
   } lcm_uword_type;

   typedef struct packed {
      logic any_zero;
      logic not_equal;
      logic div_more;
   } lcm_flags_type;

   localparam logic [PC_WIDTH-1:0] STEP_IDLE     = 3'd0;
   localparam logic [PC_WIDTH-1:0] STEP_CHECK    = 3'd1;
   localparam logic [PC_WIDTH-1:0] STEP_GCD      = 3'd2;
   localparam logic [PC_WIDTH-1:0] STEP_DIV_INIT = 3'd3;
   localparam logic [PC_WIDTH-1:0] STEP_DIV      = 3'd4;
   localparam logic [PC_WIDTH-1:0] STEP_MUL      = 3'd5;
   localparam logic [PC_WIDTH-1:0] STEP_EMIT     = 3'd6;
   localparam logic [PC_WIDTH-1:0] STEP_RETRY    = 3'd7;

   // microcode store: jump to target when the condition holds, else step on
   function automatic lcm_uword_type lcm_rom(input logic [PC_WIDTH-1:0] pc);
      lcm_uword_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (pc)
         STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_REQ,    target: STEP_IDLE};
         STEP_CHECK:    w = '{op: OP_CLEAR,    cond: COND_ANY_ZERO,  target: STEP_EMIT};
         STEP_GCD:      w = '{op: OP_GCD_STEP, cond: COND_NOT_EQUAL, target: STEP_GCD};
         STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: STEP_IDLE};
         STEP_DIV:      w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,  target: STEP_DIV};
         STEP_MUL:      w = '{op: OP_MUL,      cond: COND_NEVER,     target: STEP_IDLE};
         STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FREE,  target: STEP_IDLE};
         STEP_RETRY:    w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: STEP_EMIT};
         default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/lcm_sequencer.sv =====
`timescale 1ns / 1ps

module lcm_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  lcm_pkg::lcm_flags_type flags,
   input  logic                  req_valid,
   input  logic                  out_free,
   output lcm_pkg::lcm_op_type   op
);
   import lcm_pkg::*;

   logic [PC_WIDTH-1:0] pc_ff;
   logic [PC_WIDTH-1:0] pc_in;
   lcm_uword_type       uword;
   logic                take_jump;

   assign uword = lcm_rom(pc_ff);
   assign op    = uword.op;

   always_comb begin
      unique case (uword.cond)
         COND_NEVER:     take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_NO_REQ:    take_jump = !req_valid;
         COND_ANY_ZERO:  take_jump = flags.any_zero;
         COND_NOT_EQUAL: take_jump = flags.not_equal;
         COND_DIV_MORE:  take_jump = flags.div_more;
         COND_OUT_FREE:  take_jump = out_free;
         default:        take_jump = 1'b1;
      endcase
   end

   always_comb begin
      if (take_jump) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + PC_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/core/lcm_datapath.sv =====
`timescale 1ns / 1ps

module lcm_datapath (
   input  logic                                clock,
   input  lcm_pkg::lcm_op_type                 op,
   input  logic                                req_valid,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0]   operand_a,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0]   operand_b,
   output lcm_pkg::lcm_flags_type              flags,
   output logic [lcm_pkg::RESULT_WIDTH-1:0]    product
);
   import lcm_pkg::*;

   logic [OPERAND_WIDTH-1:0]   mag_a;
   logic [OPERAND_WIDTH-1:0]   mag_b;
   logic [OPERAND_WIDTH-1:0]   a_ff, a_in;
   logic [OPERAND_WIDTH-1:0]   b_ff, b_in;
   logic [OPERAND_WIDTH-1:0]   x_ff, x_in;
   logic [OPERAND_WIDTH-1:0]   y_ff, y_in;
   logic [COUNT_WIDTH-1:0]     k_ff, k_in;
   logic [OPERAND_WIDTH-1:0]   rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0]   quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [RESULT_WIDTH-1:0]    prod_ff, prod_in;
   logic [OPERAND_WIDTH:0]     trial;
   logic [2*OPERAND_WIDTH-1:0] full_prod;

   // two's complement magnitude; the most negative value maps to 2^(w-1)
   assign mag_a = operand_a[OPERAND_WIDTH-1] ? (~operand_a + OPERAND_WIDTH'(1)) : operand_a;
   assign mag_b = operand_b[OPERAND_WIDTH-1] ? (~operand_b + OPERAND_WIDTH'(1)) : operand_b;

   assign trial     = {rem_ff, quo_ff[OPERAND_WIDTH-1]} - {1'b0, x_ff};
   assign full_prod = quo_ff * b_ff;

   assign flags.any_zero  = (a_ff == '0) || (b_ff == '0);
   assign flags.not_equal = (x_ff != y_ff);
   assign flags.div_more  = (cnt_ff != COUNT_WIDTH'(OPERAND_WIDTH - 1));
   assign product         = prod_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      unique case (op)
         OP_LOAD: begin
            if (req_valid) begin
               a_in = mag_a;
               b_in = mag_b;
               x_in = mag_a;
               y_in = mag_b;
               k_in = '0;
            end
         end
         OP_CLEAR: begin
            prod_in = '0;
         end
         OP_GCD_STEP: begin
            // binary gcd, common powers of two counted in k
            priority if (x_ff == y_ff) begin
               x_in = x_ff;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + COUNT_WIDTH'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff > y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         OP_DIV_INIT: begin
            // a / gcd equals (a >> k) / odd part of gcd
            quo_in = a_ff >> k_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (!trial[OPERAND_WIDTH]) begin
               rem_in = trial[OPERAND_WIDTH-1:0];
               quo_in = {quo_ff[OPERAND_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[OPERAND_WIDTH-2:0], quo_ff[OPERAND_WIDTH-1]};
               quo_in = {quo_ff[OPERAND_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + COUNT_WIDTH'(1);
         end
         OP_MUL: begin
            prod_in = full_prod[RESULT_WIDTH-1:0];
         end
         OP_EMIT, OP_NOP: begin
            prod_in = prod_ff;
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/least_common_multiple.sv =====
`timescale 1ns / 1ps
// least common multiple of the magnitudes of two signed operands. each request beat
// carries operand_a and operand_b; one response beat returns lcm_value, 62 bits
// unsigned, which is 0 when either operand is zero. a small microcode program steps
// a plain datapath: binary gcd (one shift or subtract per cycle), then restoring
// division of a by the gcd, then one 32x32 multiply by b. item times differ with
// the number of gcd iterations, and an operand of zero skips straight to emitting
// a zero result. one item is worked on at a time, and a finished result waits in
// the output register so the next request beat can be taken while the response
// is still pending.

module least_common_multiple (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0] req_operand_a,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0] req_operand_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lcm_pkg::RESULT_WIDTH-1:0]  rsp_lcm_value
);
   import lcm_pkg::*;

`include "assert_macros.svh"

   lcm_op_type              op;
   lcm_flags_type           flags;
   logic [RESULT_WIDTH-1:0] product;
   logic                    out_free;
   logic                    emit_fire;
   logic                    req_accept;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_lcm_value_ff, rsp_lcm_value_in;

   // output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit_fire  = (op == OP_EMIT) && out_free;
   // requests are only taken on the idle step of the program, never in reset
   assign req_ready  = (op == OP_LOAD) && !reset;
   assign req_accept = req_valid && req_ready;

   lcm_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .flags     (flags),
      .req_valid (req_valid),
      .out_free  (out_free),
      .op        (op)
   );

   lcm_datapath u_dp (
      .clock     (clock),
      .op        (op),
      .req_valid (req_valid),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .flags     (flags),
      .product   (product)
   );

   // response holding register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_lcm_value_in = rsp_lcm_value_ff;
      if (emit_fire) begin
         rsp_valid_in     = 1'b1;
         rsp_lcm_value_in = product;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_lcm_value_ff <= rsp_lcm_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lcm_value = rsp_lcm_value_ff;

   // after a request beat the program leaves the idle step
   `ASSERT_NEXT_CYCLE(a_accept_leaves_idle, clock, reset, req_accept, !req_ready)
   // an emitted result always shows up as a pending response
   `ASSERT_NEXT_CYCLE(a_emit_shows_valid, clock, reset, emit_fire, rsp_valid)
   // the multiply step is never reached with a zero operand
   `ASSERT_SAME_CYCLE(a_mul_nonzero, clock, reset, (op == OP_MUL), !flags.any_zero)

endmodule

// ===== test/least_common_multiple_tb.sv =====
`timescale 1ns / 1ps

module least_common_multiple_tb;

   import lcm_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int RW = RESULT_WIDTH;
   localparam int RANDOM_PAIRS = 1428;

   // one request beat as the driver will present it
   typedef struct packed {
      logic [W-1:0] a;
      logic [W-1:0] b;
   } operand_pair_type;

   logic          clock         = 1'b0;
   logic          reset         = 1'b1;
   logic          req_valid     = 1'b0;
   logic          req_ready;
   logic [W-1:0]  req_operand_a = '0;
   logic [W-1:0]  req_operand_b = '0;
   logic          rsp_valid;
   logic          rsp_ready     = 1'b0;
   logic [RW-1:0] rsp_lcm_value;

   operand_pair_type pending_pairs[$];   // filled up front, drained by the driver
   logic [RW-1:0] lcm_expected[$];    // one entry per accepted request beat
   logic [RW-1:0] lcm_wanted;
   int            error_count = 0;

   // request handshake seen at the last rising edge, read by the driver at the falling edge
   logic          req_taken   = 1'b0;
   int            req_gap     = 0;
   bit            req_calm    = 1'b0;
   int            rsp_stall   = 0;
   bit            rsp_calm    = 1'b0;

   least_common_multiple dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lcm_value (rsp_lcm_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // exact magnitude of a two's complement operand; the most negative value maps to 2^(W-1)
   function automatic logic [63:0] magnitude_of(input logic [W-1:0] raw);
      logic [W-1:0] neg;
      neg = -raw;
      return raw[W-1] ? 64'(neg) : 64'(raw);
   endfunction

   // lcm of magnitudes via euclid: (|a| / gcd) * |b|, zero if either side is zero
   function automatic logic [RW-1:0] lcm_of(input logic [W-1:0] a_raw,
                                            input logic [W-1:0] b_raw);
      logic [63:0] a, b, x, y, r;
      a = magnitude_of(a_raw);
      b = magnitude_of(b_raw);
      if (a == 0 || b == 0)
         return '0;
      x = a;
      y = b;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return RW'((a / x) * b);
   endfunction

   function automatic logic [W-1:0] with_sign(input logic [W-1:0] v,
                                              input int unsigned neg);
      return (neg != 0) ? -v : v;
   endfunction

   // mostly back to back, some short pauses, the odd long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      int            kind;
      logic [W-1:0]  g, m, n;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         // full width noise, every bit free
         p.a = $urandom;
         p.b = $urandom;
      end else if (kind < 55) begin
         // common factor so the gcd loop and the division do real work
         g   = $urandom_range(1, 65535);
         m   = $urandom_range(1, 32767);
         n   = $urandom_range(1, 32767);
         p.a = with_sign(g * m, $urandom_range(0, 1));
         p.b = with_sign(g * n, $urandom_range(0, 1));
      end else if (kind < 70) begin
         p.a = with_sign($urandom_range(0, 64), $urandom_range(0, 1));
         p.b = with_sign($urandom_range(0, 64), $urandom_range(0, 1));
      end else if (kind < 80) begin
         // powers of two times a small odd number
         p.a = with_sign(($urandom_range(0, 15) * 2 + 1) << $urandom_range(0, 27),
                         $urandom_range(0, 1));
         p.b = with_sign(($urandom_range(0, 15) * 2 + 1) << $urandom_range(0, 27),
                         $urandom_range(0, 1));
      end else if (kind < 88) begin
         // equal magnitudes, sign free
         p.a = $urandom;
         p.b = with_sign(p.a, $urandom_range(0, 1));
      end else if (kind < 93) begin
         // zero on one side or both
         p.a = $urandom_range(0, 1) ? '0 : W'($urandom);
         p.b = (p.a != 0 || $urandom_range(0, 1)) ? '0 : W'($urandom);
      end else if (kind < 97) begin
         // most negative value against anything
         p.a = {1'b1, {(W-1){1'b0}}};
         p.b = $urandom_range(0, 1) ? W'($urandom) : W'($urandom_range(0, 255));
         if ($urandom_range(0, 1))
            p = '{a: p.b, b: p.a};
      end else begin
         // just inside the extremes
         p.a = {1'b0, {(W-1){1'b1}}} - W'($urandom_range(0, 40));
         p.b = {1'b1, {(W-1){1'b0}}} + W'($urandom_range(0, 40));
      end
      return p;
   endfunction

   // stimulus: directed corners first, then the random mix; ends the run once drained
   initial begin
      pending_pairs.push_back('{a: 0, b: 0});
      pending_pairs.push_back('{a: 0, b: 5});
      pending_pairs.push_back('{a: -7, b: 0});
      pending_pairs.push_back('{a: 0, b: 32'h8000_0000});
      pending_pairs.push_back('{a: 1, b: 1});
      pending_pairs.push_back('{a: -1, b: 1});
      pending_pairs.push_back('{a: 12, b: 12});
      pending_pairs.push_back('{a: -12, b: 12});
      pending_pairs.push_back('{a: 12, b: 18});
      pending_pairs.push_back('{a: 7, b: 13});
      pending_pairs.push_back('{a: 6, b: -4});
      pending_pairs.push_back('{a: -6, b: -4});
      pending_pairs.push_back('{a: 32'h8000_0000, b: 32'h8000_0000});
      pending_pairs.push_back('{a: 32'h8000_0000, b: 32'h7fff_ffff});
      pending_pairs.push_back('{a: 32'h7fff_ffff, b: 32'h7fff_fffe});
      pending_pairs.push_back('{a: 32'h8000_0001, b: 32'h7fff_fffe});
      pending_pairs.push_back('{a: 32'hffff_ffff, b: 32'h8000_0000});
      pending_pairs.push_back('{a: 1, b: 32'h7fff_ffff});
      pending_pairs.push_back('{a: 32'h7fff_ffff, b: 32'h7fff_ffff});
      pending_pairs.push_back('{a: 32'h0001_0000, b: 32'h0003_0000});
      pending_pairs.push_back('{a: 32'h5555_5555, b: 32'haaaa_aaaa});
      pending_pairs.push_back('{a: 32'h4000_0000, b: 3});
      repeat (RANDOM_PAIRS)
         pending_pairs.push_back(random_pair());

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every beat accepted, then every response back, then a quiet spell for strays
      do @(posedge clock); while (pending_pairs.size() != 0 || req_valid);
      do @(posedge clock); while (lcm_expected.size() != 0);
      repeat (300) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // request driver: holds a beat until taken, then an optional gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // still waiting for the handshake
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap = req_gap - 1;
      end else if (pending_pairs.size() != 0) begin
         operand_pair_type p;
         p = pending_pairs.pop_front();
         req_valid     <= 1'b1;
         req_operand_a <= p.a;
         req_operand_b <= p.b;
         if ($urandom_range(0, 199) == 0)
            req_calm = !req_calm;
         req_gap = req_calm ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response back-pressure: stalls of random length, with calm stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 999) == 0)
            rsp_calm = !rsp_calm;
         if (rsp_stall == 0 && !rsp_calm && $urandom_range(0, 3) == 0)
            rsp_stall = pick_gap();
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall = rsp_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: check response beats in order, queue a prediction per request beat
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (lcm_expected.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response beat, expected none, got lcm_value %0d",
                        $time, rsp_lcm_value);
            end else begin
               lcm_wanted = lcm_expected.pop_front();
               if (rsp_lcm_value !== lcm_wanted) begin
                  error_count++;
                  $display("%0t: lcm_value mismatch, expected %0d, got %0d",
                           $time, lcm_wanted, rsp_lcm_value);
               end
            end
         end
         if (req_valid && req_ready)
            lcm_expected.push_back(lcm_of(req_operand_a, req_operand_b));
      end
   end

endmodule

// ===== least_common_multiple.f =====
+incdir+rtl/core
rtl/core/lcm_pkg.sv
rtl/core/lcm_sequencer.sv
rtl/core/lcm_datapath.sv
rtl/core/least_common_multiple.sv
test/least_common_multiple_tb.sv
